// ----- design/dpc_pkg.sv -----
// Shared widths, register indexes and types of the distinct point counter.
package dpc_pkg;

    // Field widths
    localparam int ID_W        = 16;
    localparam int COORD_W     = 24;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int SQ_W        = 2 * COORD_W + 1;
    localparam int DIST_W      = SQ_W + 1;
    localparam int RADIUS_W    = 48;
    localparam int STOP_W      = 7;
    localparam int COUNT_OUT_W = 7;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RADIUS_W;

    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_SIDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_AT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ  = 2'd2;

    // Register reset values
    localparam logic                QUERY_SIDE_RST = 1'b1;
    localparam logic [STOP_W-1:0]   STOP_AT_RST    = 7'd64;
    localparam logic [RADIUS_W-1:0] RADIUS_SQ_RST  = '0;

    // Default table depth
    localparam int MAX_KEPT_DEF = 64;

    // One point: id and position
    typedef struct packed {
        logic [ID_W-1:0]           id;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_point;

    // Control broadcast to every cell
    typedef struct packed {
        logic clear;   // drop all kept points (new set)
        logic shift;   // append probe at the head, move entries one cell down
    } t_cell_ctrl;

endpackage

// ----- design/dpc_in_if.sv -----
// Request channel carrying one point match.
interface dpc_in_if;
    import dpc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      first_item;
    logic [ID_W-1:0]           q_id;
    logic signed [COORD_W-1:0] q_x;
    logic signed [COORD_W-1:0] q_y;
    logic [ID_W-1:0]           db_id;
    logic signed [COORD_W-1:0] db_x;
    logic signed [COORD_W-1:0] db_y;
    logic                      last_item;

    modport source (
        output valid, first_item, q_id, q_x, q_y, db_id, db_x, db_y, last_item,
        input  ready
    );

    modport sink (
        input  valid, first_item, q_id, q_x, q_y, db_id, db_x, db_y, last_item,
        output ready
    );
endinterface

// ----- design/dpc_out_if.sv -----
// Result channel: kept flag, running distinct count and end-of-set echo.
interface dpc_out_if;
    import dpc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   kept;
    logic [COUNT_OUT_W-1:0] distinct_count;
    logic                   set_done;

    modport source (
        output valid, kept, distinct_count, set_done,
        input  ready
    );

    modport sink (
        input  valid, kept, distinct_count, set_done,
        output ready
    );
endinterface

// ----- design/dpc_cell.sv -----
// One table cell: holds a kept point, tests it against the probe, passes the hit flag on.
module dpc_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dpc_pkg::t_cell_ctrl                 i_ctrl,
    input  dpc_pkg::t_point                     i_probe,
    input  logic [dpc_pkg::RADIUS_W-1:0]        i_radius_sq,
    input  dpc_pkg::t_point                     i_prev_point,
    input  logic                                i_prev_valid,
    input  logic                                i_prev_acc,
    output dpc_pkg::t_point                     o_point,
    output logic                                o_valid,
    output logic                                o_acc
);
    import dpc_pkg::*;

    t_point                r_point;
    logic                  r_valid;
    logic [SQ_W-1:0]       r_dx2;
    logic [SQ_W-1:0]       r_dy2;
    logic                  r_id_eq;
    logic                  r_hit;
    logic                  r_acc;

    logic signed [DIFF_W-1:0] diff_x;
    logic signed [DIFF_W-1:0] diff_y;
    logic [DIFF_W-1:0]        abs_x;
    logic [DIFF_W-1:0]        abs_y;
    logic [2*DIFF_W-1:0]      prod_x;
    logic [2*DIFF_W-1:0]      prod_y;
    logic [DIST_W-1:0]        dist_sq;

    // Exact differences and magnitudes
    assign diff_x = DIFF_W'(i_probe.x) - DIFF_W'(r_point.x);
    assign diff_y = DIFF_W'(i_probe.y) - DIFF_W'(r_point.y);
    assign abs_x  = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
    assign abs_y  = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);
    assign prod_x = abs_x * abs_x;
    assign prod_y = abs_y * abs_y;

    // Squared distance, compared in the second stage
    assign dist_sq = DIST_W'(r_dx2) + DIST_W'(r_dy2);

    // Stored entry: cleared on a new set, shifted in on an append
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_valid <= i_prev_valid;
        end
        if (i_ctrl.shift) begin
            r_point <= i_prev_point;
        end
    end

    // Squares, then hit test, then hit flag handed down the row
    always_ff @(posedge i_clk) begin
        r_dx2   <= prod_x[SQ_W-1:0];
        r_dy2   <= prod_y[SQ_W-1:0];
        r_id_eq <= (i_probe.id == r_point.id);
        if (!i_rst_n) begin
            r_hit <= 1'b0;
            r_acc <= 1'b0;
        end else begin
            r_hit <= r_valid && (r_id_eq || (dist_sq < DIST_W'(i_radius_sq)));
            r_acc <= r_hit || i_prev_acc;
        end
    end

    assign o_point = r_point;
    assign o_valid = r_valid;
    assign o_acc   = r_acc;

endmodule

// ----- design/distinct_point_counter.sv -----
// Distinct point counter: keeps matches whose point is far from, and differs in id from,
// every point already kept in the current set, and reports the running count.
//
// Kept points live in a row of MAX_KEPT cells; a new point enters at the head and every
// entry moves one cell down. Each item is compared against all cells at once, and the
// reject flag then ripples down the row one cell per clock. The block takes one item
// at a time and commits its result only once the walk is done and the output register
// is free or being read; a result waits in an output register while the next item is
// accepted. radius_sq holds a squared radius in units of 2^-16 square pixels; a stop
// limit above MAX_KEPT acts as MAX_KEPT and a limit of zero ignores every item.
module distinct_point_counter #(
    parameter int MAX_KEPT = dpc_pkg::MAX_KEPT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dpc_in_if.sink                          i_in,
    dpc_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [dpc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dpc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import dpc_pkg::*;

    localparam int CNT_W  = $clog2(MAX_KEPT + 1);
    localparam int LIM_W  = (CNT_W > STOP_W) ? CNT_W : STOP_W;
    localparam int WAIT_W = $clog2(MAX_KEPT + 3);
    localparam logic [WAIT_W-1:0] WAIT_LOAD = WAIT_W'(MAX_KEPT + 2);

    typedef enum logic {S_IDLE, S_WALK} t_state;

    // Configuration registers
    logic                r_query_side;
    logic [STOP_W-1:0]   r_stop_at;
    logic [RADIUS_W-1:0] r_radius_sq;

    // Control and output registers
    t_state                 r_state;
    logic [WAIT_W-1:0]      r_wait;
    t_point                 r_probe;
    logic                   r_last;
    logic [CNT_W-1:0]       r_count;
    logic                   r_out_valid;
    logic                   r_out_kept;
    logic [COUNT_OUT_W-1:0] r_out_count;
    logic                   r_out_done;

    logic [CNT_W-1:0] n_count;
    t_point           n_probe;

    logic       accept;
    logic       out_free;
    logic       commit;
    logic       below_limit;
    logic       keep;
    t_cell_ctrl cell_ctrl;

    t_point chain_point [MAX_KEPT];
    logic   chain_valid [MAX_KEPT];
    logic   chain_acc   [MAX_KEPT];

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_side <= QUERY_SIDE_RST;
            r_stop_at    <= STOP_AT_RST;
            r_radius_sq  <= RADIUS_SQ_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_QUERY_SIDE: r_query_side <= i_cfg_data[0];
                CFG_STOP_AT:    r_stop_at    <= i_cfg_data[STOP_W-1:0];
                CFG_RADIUS_SQ:  r_radius_sq  <= i_cfg_data[RADIUS_W-1:0];
                default:        ;
            endcase
        end
    end

    // Handshake and decision
    assign accept      = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign commit      = (r_state == S_WALK) && (r_wait == '0) && out_free;
    assign below_limit = (LIM_W'(r_count) < LIM_W'(r_stop_at))
                         && (r_count < CNT_W'(MAX_KEPT));
    assign keep        = commit && below_limit && !chain_acc[MAX_KEPT-1];

    assign cell_ctrl.clear = accept && i_in.first_item;
    assign cell_ctrl.shift = keep;

    // Side select and count update
    always_comb begin
        if (r_query_side) begin
            n_probe.id = i_in.q_id;
            n_probe.x  = i_in.q_x;
            n_probe.y  = i_in.q_y;
        end else begin
            n_probe.id = i_in.db_id;
            n_probe.x  = i_in.db_x;
            n_probe.y  = i_in.db_y;
        end
        n_count = r_count;
        if (accept && i_in.first_item) begin
            n_count = '0;
        end else if (keep) begin
            n_count = r_count + 1'b1;
        end
    end

    // Sequencer with output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            // a commit in the same cycle reloads the output register instead
            if (o_out.valid && o_out.ready && !commit) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_probe <= n_probe;
                        r_last  <= i_in.last_item;
                        r_wait  <= WAIT_LOAD;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_wait != '0) begin
                        r_wait <= r_wait - 1'b1;
                    end else if (commit) begin
                        r_out_valid <= 1'b1;
                        r_out_kept  <= keep;
                        r_out_count <= COUNT_OUT_W'(n_count);
                        r_out_done  <= r_last;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.kept           = r_out_kept;
    assign o_out.distinct_count = r_out_count;
    assign o_out.set_done       = r_out_done;

    // Row of cells; the head takes the probe and an empty reject flag
    for (genvar gi = 0; gi < MAX_KEPT; gi++) begin : g_cell
        if (gi == 0) begin : g_head
            dpc_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (cell_ctrl),
                .i_probe      (r_probe),
                .i_radius_sq  (r_radius_sq),
                .i_prev_point (r_probe),
                .i_prev_valid (1'b1),
                .i_prev_acc   (1'b0),
                .o_point      (chain_point[gi]),
                .o_valid      (chain_valid[gi]),
                .o_acc        (chain_acc[gi])
            );
        end else begin : g_body
            dpc_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (cell_ctrl),
                .i_probe      (r_probe),
                .i_radius_sq  (r_radius_sq),
                .i_prev_point (chain_point[gi-1]),
                .i_prev_valid (chain_valid[gi-1]),
                .i_prev_acc   (chain_acc[gi-1]),
                .o_point      (chain_point[gi]),
                .o_valid      (chain_valid[gi]),
                .o_acc        (chain_acc[gi])
            );
        end
    end

endmodule

// ----- design/dpc_checker.sv -----
// Port-level checks of the distinct point counter, bound to its top level.
module dpc_checker #(
    parameter int MAX_KEPT = dpc_pkg::MAX_KEPT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic                              i_out_kept,
    input  logic [dpc_pkg::COUNT_OUT_W-1:0]   i_out_count,
    input  logic                              i_out_done
);
    import dpc_pkg::*;

    // Reset leaves no result pending and the input open
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("result pending or input closed after reset");

    // An accepted request keeps the input closed at the start of its walk down the row
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready ##1 !i_in_ready)
        else $error("request accepted during a table walk");

    // A stalled result holds its fields
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            i_out_valid && $stable(i_out_kept) && $stable(i_out_count)
            && $stable(i_out_done))
        else $error("stalled result changed");

    // A kept point implies a nonzero count when the count cannot wrap
    if (MAX_KEPT < (1 << COUNT_OUT_W)) begin : g_count_chk
        a_kept_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (i_out_valid && i_out_kept) |-> (i_out_count != '0))
            else $error("point kept with zero count");
    end

endmodule

bind distinct_point_counter dpc_checker #(.MAX_KEPT(MAX_KEPT)) u_dpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kept  (o_out.kept),
    .i_out_count (o_out.distinct_count),
    .i_out_done  (o_out.set_done)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for the distinct point counter: directed and random match streams.
`timescale 1ns / 100ps

module testbench;
    import dpc_pkg::*;

    localparam int MAX_KEPT     = MAX_KEPT_DEF;
    localparam int DRAIN_CYCLES = MAX_KEPT + 8;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int MAX_PRINT    = 40;
    localparam int COORD_MAX    = (1 << (COORD_W - 1)) - 1;
    localparam int COORD_MIN    = -(1 << (COORD_W - 1));

    // Index past the last register; writes to it must have no effect
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic                      first_item;
        logic [ID_W-1:0]           q_id;
        logic signed [COORD_W-1:0] q_x;
        logic signed [COORD_W-1:0] q_y;
        logic [ID_W-1:0]           db_id;
        logic signed [COORD_W-1:0] db_x;
        logic signed [COORD_W-1:0] db_y;
        logic                      last_item;
    } t_match_req;

    typedef struct {
        logic                   kept;
        logic [COUNT_OUT_W-1:0] distinct_count;
        logic                   set_done;
    } t_match_res;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    dpc_in_if  req_if ();
    dpc_out_if res_if ();

    distinct_point_counter #(
        .MAX_KEPT (MAX_KEPT)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (req_if.sink),
        .o_out      (res_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predicted block state and register copy
    t_point                kept_tab [MAX_KEPT];
    int unsigned           kept_n     = 0;
    logic                  cfg_q_side = QUERY_SIDE_RST;
    logic [STOP_W-1:0]     cfg_stop   = STOP_AT_RST;
    logic [RADIUS_W-1:0]   cfg_radius = RADIUS_SQ_RST;

    t_match_req  req_q [$];
    t_match_res  pending_res [$];
    t_match_req  drv_cur;
    t_match_res  want;
    bit          drv_busy   = 1'b0;
    int unsigned gap_left   = 0;
    int unsigned stall_left = 0;
    int unsigned idle_max   = 12;
    int unsigned err_cnt    = 0;
    int unsigned n_acc      = 0;
    int unsigned n_res      = 0;
    int unsigned n_kept     = 0;
    int unsigned cyc        = 0;

    initial forever #2 i_clk = ~i_clk;

    // Known values on the request and result channels before the first edge
    initial begin
        req_if.valid      = 1'b0;
        req_if.first_item = 1'b0;
        req_if.q_id       = '0;
        req_if.q_x        = '0;
        req_if.q_y        = '0;
        req_if.db_id      = '0;
        req_if.db_x       = '0;
        req_if.db_y       = '0;
        req_if.last_item  = 1'b0;
        res_if.ready      = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        if (err_cnt < MAX_PRINT)
            $display("[%0t] mismatch: %s", $time, what);
        err_cnt++;
    endtask

    function automatic int unsigned idle_draw();
        if (idle_max == 0 || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, idle_max);
    endfunction

    // Greedy dedup: keep the point if it clears every kept point by id and radius
    function automatic t_match_res count_distinct(input t_match_req r);
        t_point      p;
        int unsigned lim;
        bit          hit;
        longint      dx;
        longint      dy;
        longint      d2;
        t_match_res  res;
        if (r.first_item)
            kept_n = 0;
        lim = (cfg_stop > MAX_KEPT) ? MAX_KEPT : cfg_stop;
        if (cfg_q_side) begin
            p.id = r.q_id;
            p.x  = r.q_x;
            p.y  = r.q_y;
        end else begin
            p.id = r.db_id;
            p.x  = r.db_x;
            p.y  = r.db_y;
        end
        res.kept = 1'b0;
        if (kept_n < lim) begin
            hit = 1'b0;
            for (int j = 0; j < kept_n; j++) begin
                dx = longint'($signed(kept_tab[j].x)) - longint'($signed(p.x));
                dy = longint'($signed(kept_tab[j].y)) - longint'($signed(p.y));
                d2 = dx * dx + dy * dy;
                if (kept_tab[j].id == p.id || d2 < longint'({16'b0, cfg_radius}))
                    hit = 1'b1;
            end
            if (!hit) begin
                kept_tab[kept_n] = p;
                kept_n++;
                res.kept = 1'b1;
            end
        end
        res.distinct_count = COUNT_OUT_W'(kept_n);
        res.set_done       = r.last_item;
        return res;
    endfunction

    // Request driver: one match per request, random gap after each acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            drv_busy = 1'b0;
            gap_left = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                pending_res.push_back(count_distinct(drv_cur));
                n_acc++;
                drv_busy = 1'b0;
                gap_left = idle_draw();
            end
            if (!drv_busy) begin
                if (gap_left == 0 && req_q.size() != 0) begin
                    drv_cur = req_q.pop_front();
                    req_if.first_item <= drv_cur.first_item;
                    req_if.q_id       <= drv_cur.q_id;
                    req_if.q_x        <= drv_cur.q_x;
                    req_if.q_y        <= drv_cur.q_y;
                    req_if.db_id      <= drv_cur.db_id;
                    req_if.db_x       <= drv_cur.db_x;
                    req_if.db_y       <= drv_cur.db_y;
                    req_if.last_item  <= drv_cur.last_item;
                    req_if.valid      <= 1'b1;
                    drv_busy = 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left--;
                end
            end
        end
    end

    // Result monitor: compare against the oldest prediction, random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                n_res++;
                if (res_if.kept === 1'b1)
                    n_kept++;
                if (pending_res.size() == 0) begin
                    flag_mismatch("result with no request outstanding");
                end else begin
                    want = pending_res.pop_front();
                    if (res_if.kept !== want.kept)
                        flag_mismatch($sformatf("result %0d kept %b, expected %b",
                                                n_res, res_if.kept, want.kept));
                    if (res_if.distinct_count !== want.distinct_count)
                        flag_mismatch($sformatf("result %0d count %0d, expected %0d",
                                                n_res, res_if.distinct_count,
                                                want.distinct_count));
                    if (res_if.set_done !== want.set_done)
                        flag_mismatch($sformatf("result %0d set_done %b, expected %b",
                                                n_res, res_if.set_done, want.set_done));
                end
                stall_left = idle_draw();
            end
            if (stall_left != 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cyc++;
        if (cyc >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d requests, %0d results",
                     cyc, n_acc, n_res);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic t_match_req rand_match();
        t_match_req r;
        r.first_item = 1'($urandom_range(0, 1));
        r.q_id       = ID_W'($urandom);
        r.q_x        = COORD_W'($urandom);
        r.q_y        = COORD_W'($urandom);
        r.db_id      = ID_W'($urandom);
        r.db_x       = COORD_W'($urandom);
        r.db_y       = COORD_W'($urandom);
        r.last_item  = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_MAX)
            return COORD_MAX;
        if (v < COORD_MIN)
            return COORD_MIN;
        return v;
    endfunction

    function automatic longint rand_span(input longint half);
        return longint'($urandom_range(0, 32'(2 * half))) - half;
    endfunction

    // Queue one match; the side picked by the side register carries the point, the other
    // is noise
    task automatic queue_point(input bit first, input bit last, input logic [ID_W-1:0] id,
                               input longint x, input longint y);
        t_match_req r;
        r            = rand_match();
        r.first_item = first;
        r.last_item  = last;
        if (cfg_q_side) begin
            r.q_id = id;
            r.q_x  = x[COORD_W-1:0];
            r.q_y  = y[COORD_W-1:0];
        end else begin
            r.db_id = id;
            r.db_x  = x[COORD_W-1:0];
            r.db_y  = y[COORD_W-1:0];
        end
        req_q.push_back(r);
    endtask

    // One set: fresh points around a center, near repeats and repeated ids mixed in
    task automatic queue_set(input int unsigned len, input int unsigned near_raw,
                             input int unsigned spread);
        longint          xs [$];
        longint          ys [$];
        logic [ID_W-1:0] ids [$];
        longint          lim;
        longint          cx;
        longint          cy;
        longint          x;
        longint          y;
        logic [ID_W-1:0] id;
        int unsigned     pick;
        int unsigned     k;
        bit              drop_first;
        bit              drop_last;
        lim = longint'(COORD_MAX) - spread - near_raw - 2;
        if (lim < 0)
            lim = 0;
        cx = rand_span(lim);
        cy = rand_span(lim);
        drop_first = ($urandom_range(0, 19) == 0);
        drop_last  = ($urandom_range(0, 19) == 0);
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (i > 0 && pick < 20) begin
                k  = $urandom_range(0, i - 1);
                x  = xs[k] + rand_span(near_raw + 2);
                y  = ys[k] + rand_span(near_raw + 2);
                id = ID_W'($urandom);
            end else if (i > 0 && pick < 26) begin
                k  = $urandom_range(0, i - 1);
                x  = cx + rand_span(spread);
                y  = cy + rand_span(spread);
                id = ids[k];
            end else begin
                x  = cx + rand_span(spread);
                y  = cy + rand_span(spread);
                id = ID_W'($urandom);
            end
            x = clamp_coord(x);
            y = clamp_coord(y);
            xs.push_back(x);
            ys.push_back(y);
            ids.push_back(id);
            queue_point((i == 0) && !drop_first, (i == len - 1) && !drop_last, id, x, y);
        end
    endtask

    // Idle means nothing queued, nothing on the channel and no result outstanding
    task automatic wait_idle();
        while (req_q.size() != 0 || drv_busy || pending_res.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_QUERY_SIDE: cfg_q_side = val[0];
            CFG_STOP_AT:    cfg_stop   = val[STOP_W-1:0];
            CFG_RADIUS_SQ:  cfg_radius = val[RADIUS_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic uq, input logic [STOP_W-1:0] stop,
                             input logic [RADIUS_W-1:0] rad, input int unsigned near_raw,
                             input int unsigned spread, input int unsigned max_len,
                             input int unsigned n_items, input int unsigned idle);
        int unsigned queued;
        int unsigned len;
        queued = 0;
        wait_idle();
        set_reg(CFG_QUERY_SIDE, CFG_DATA_W'(uq));
        set_reg(CFG_STOP_AT, CFG_DATA_W'(stop));
        set_reg(CFG_RADIUS_SQ, CFG_DATA_W'(rad));
        idle_max = idle;
        while (queued < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: random content, random first/last flags
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    req_q.push_back(rand_match());
            end else begin
                len = $urandom_range(1, max_len);
                queue_set(len, near_raw, spread);
            end
            queued += len;
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: query side, limit 64, zero radius
        queue_point(1'b1, 1'b0, 16'h0000, COORD_MAX, COORD_MIN);
        queue_point(1'b0, 1'b0, 16'hFFFF, COORD_MIN, COORD_MAX);
        queue_point(1'b0, 1'b0, 16'h0000, 0, 0);                  // same id, rejected
        queue_point(1'b0, 1'b0, 16'h0005, COORD_MAX, COORD_MIN);  // same spot, zero radius
        queue_point(1'b0, 1'b1, 16'h0006, -1, -1);

        // Database side, limit 2, largest radius: only opposite corners clear it
        wait_idle();
        set_reg(CFG_QUERY_SIDE, '0);
        set_reg(CFG_STOP_AT, CFG_DATA_W'(2));
        set_reg(CFG_RADIUS_SQ, {CFG_DATA_W{1'b1}});
        queue_point(1'b1, 1'b0, 16'h0001, COORD_MIN, COORD_MIN);
        queue_point(1'b0, 1'b0, 16'h0002, COORD_MAX, COORD_MAX);
        queue_point(1'b0, 1'b0, 16'h0003, 0, 0);                  // limit reached
        queue_point(1'b0, 1'b1, 16'h0004, COORD_MIN, COORD_MAX);

        // Limit of zero ignores everything
        wait_idle();
        set_reg(CFG_STOP_AT, '0);
        queue_point(1'b1, 1'b0, 16'h0010, 0, 0);
        queue_point(1'b0, 1'b1, 16'h0011, COORD_MAX, 0);

        // Limit above capacity, radius of one pixel, write to an unused index
        wait_idle();
        set_reg(CFG_QUERY_SIDE, CFG_DATA_W'(1));
        set_reg(CFG_STOP_AT, CFG_DATA_W'(127));
        set_reg(CFG_RADIUS_SQ, CFG_DATA_W'(65536));
        set_reg(CFG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));
        queue_point(1'b1, 1'b0, 16'h0007, 0, 0);
        queue_point(1'b0, 1'b0, 16'h0008, 255, 0);                // just inside radius
        queue_point(1'b0, 1'b0, 16'h0009, 256, 0);                // exactly on radius
        queue_point(1'b0, 1'b0, 16'h000A, 0, -256);
        queue_point(1'b0, 1'b1, 16'h0007, COORD_MAX, COORD_MAX);  // far, but same id
        queue_point(1'b1, 1'b0, 16'h000B, 100, 100);
        queue_point(1'b1, 1'b1, 16'h000B, 100, 100);              // restart without end

        // Random phases
        run_phase(1'b1, 7'd64,  48'(2560 * 2560), 2560, 40000, 40, 180, 12);
        run_phase(1'b0, 7'd1,   48'(100 * 100),   100,  5000,  8,  180, 12);
        run_phase(1'b0, 7'd127, '0,               2,    30,    90, 180, 12);
        run_phase(1'b1, 7'd20,  48'(5000 * 5000), 5000, 60000, 30, 180, 3);
        run_phase(1'b1, 7'd0,   48'd1234567,      1000, 10000, 10, 40,  12);
        run_phase(1'b0, 7'd64,  {RADIUS_W{1'b1}}, 1 << 20, COORD_MAX, 40, 180, 12);
        run_phase(1'b1, 7'd64,  48'(64 * 64),     64,   1500,  70, 180, 0);
        wait_idle();
        set_reg(CFG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));
        run_phase(1'b0, 7'd33,  48'($urandom_range(0, 1 << 20)), 1000, 20000, 50, 180, 12);

        wait_idle();
        $display("covered %0d matches and %0d results, %0d points kept, over 12 settings",
                 n_acc, n_res, n_kept);
        $display("limits 0, 1, 2, 20, 33, 64 and 127; radius from zero to full scale");
        if (err_cnt == 0 && pending_res.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
